/* rtl/swt_pkg.sv */
// Package for the shell word tokenizer: character codes, quote modes and
// the per-byte result record passed from the parser to the top level.
// No dependencies.
package swt_pkg;

  localparam logic [7:0] ChrAmp       = 8'h26;  // '&'
  localparam logic [7:0] ChrSpace     = 8'h20;  // ' '
  localparam logic [7:0] ChrBackslash = 8'h5C;  // '\'
  localparam logic [7:0] ChrDquote    = 8'h22;  // '"'
  localparam logic [7:0] ChrSquote    = 8'h27;  // single quote

  localparam logic [1:0] QuoteNone   = 2'd0;
  localparam logic [1:0] QuoteSingle = 2'd1;
  localparam logic [1:0] QuoteDouble = 2'd2;

  localparam int unsigned OutDataW = 16;

  typedef struct packed {
    logic       has_out;    // this byte yields a result beat
    logic       char_valid;
    logic [7:0] word_char;
    logic       word_end;
    logic       line_done;
    logic       run_bg;
    logic       syn_err;
  } swt_result_t;

endpackage

/* rtl/swt_parse.sv */
// Tokenizer state machine: quote mode, escape, open word and ampersand
// flags, plus the combinational per-byte decode. Depends on swt_pkg.
module swt_parse (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,   // consume byte_i/last_i this cycle
  input  logic [7:0]           byte_i,
  input  logic                 last_i,
  output swt_pkg::swt_result_t res_o
);

  logic [1:0] quote_q, quote_d;
  logic       esc_q, esc_d;
  logic       word_q, word_d;
  logic       amp_q, amp_d;

  logic       have_char;
  logic       ended;
  logic [7:0] closer;
  logic       err;

  always_comb begin
    quote_d   = quote_q;
    esc_d     = esc_q;
    word_d    = word_q;
    amp_d     = amp_q;
    have_char = 1'b0;
    ended     = 1'b0;
    // mode 3 never arises; it closes like single quote
    closer = (quote_q == swt_pkg::QuoteDouble) ? swt_pkg::ChrDquote : swt_pkg::ChrSquote;

    if (esc_q) begin
      have_char = 1'b1;
      esc_d     = 1'b0;
    end else if (byte_i == swt_pkg::ChrBackslash) begin
      word_d = 1'b1;
      esc_d  = 1'b1;
    end else if (quote_q != swt_pkg::QuoteNone) begin
      if (byte_i == closer) begin
        quote_d = swt_pkg::QuoteNone;
      end else begin
        have_char = 1'b1;
      end
    end else if (byte_i == swt_pkg::ChrSpace || byte_i == swt_pkg::ChrAmp) begin
      if (byte_i == swt_pkg::ChrAmp) begin
        amp_d = 1'b1;
      end
      if (word_q) begin
        ended  = 1'b1;
        word_d = 1'b0;
      end
    end else begin
      word_d = 1'b1;
      if (byte_i == swt_pkg::ChrSquote) begin
        quote_d = swt_pkg::QuoteSingle;
      end else if (byte_i == swt_pkg::ChrDquote) begin
        quote_d = swt_pkg::QuoteDouble;
      end else begin
        have_char = 1'b1;
      end
    end

    err = last_i && (esc_d || quote_d != swt_pkg::QuoteNone);

    res_o.has_out    = last_i || have_char || ended;
    res_o.char_valid = have_char && !err;
    res_o.word_char  = (have_char && !err) ? byte_i : 8'h00;
    res_o.word_end   = !err && (ended || (last_i && word_d));
    res_o.line_done  = last_i;
    res_o.run_bg     = last_i && !err && amp_d;
    res_o.syn_err    = err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quote_q <= swt_pkg::QuoteNone;
      esc_q   <= 1'b0;
      word_q  <= 1'b0;
      amp_q   <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        // line finished: back to the reset state
        quote_q <= swt_pkg::QuoteNone;
        esc_q   <= 1'b0;
        word_q  <= 1'b0;
        amp_q   <= 1'b0;
      end else begin
        quote_q <= quote_d;
        esc_q   <= esc_d;
        word_q  <= word_d;
        amp_q   <= amp_d;
      end
    end
  end

endmodule

/* rtl/shell_word_tokenizer.sv */
// Shell word tokenizer, top level: input register, parser, output register.
// Depends on swt_pkg and swt_parse.
//
// Usage:
//   Slave stream: one command-line byte per beat in s_axis_tdata_i, with
//   s_axis_tlast_i on the final byte of the line.
//   Master stream: at most one beat per input byte. A beat carries a word
//   character (tuser high), a word-end mark, or, with tlast, the end of the
//   line with the background and syntax-error flags. Bytes that add no
//   character and end no word (skipped blanks, quotes, backslashes) give no
//   beat; the final byte always gives one.
//   An input beat reaches the output through the input register, then the
//   result register. Throughput is one byte per cycle while m_axis_tready_i
//   stays high; the combinational parse between the two registers sets it.
//   Reset clears the tokenizer state and both stage valids; the end of each
//   line returns the state to its reset values.
//   When the receiver holds m_axis_tready_i low, the result register holds,
//   the input register fills, and s_axis_tready_o drops; nothing is lost.
module shell_word_tokenizer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [7:0]                    s_axis_tdata_i,  // [7:0] in_byte
  input  logic                          s_axis_tlast_i,  // end_of_line
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [7:0] word_char, [8] word_end, [9] run_in_background, [10] syntax_error
  output logic [swt_pkg::OutDataW-1:0]  m_axis_tdata_o,
  output logic                          m_axis_tuser_o,  // char_valid
  output logic                          m_axis_tlast_o   // line_done
);

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       out_vld_q;
  logic       out_free;
  logic       adv;

  swt_pkg::swt_result_t res;
  swt_pkg::swt_result_t out_q;

  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign adv             = in_vld_q && out_free;
  assign s_axis_tready_o = !in_vld_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  swt_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= adv && res.has_out;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res.has_out) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = out_q.char_valid;
  assign m_axis_tlast_o  = out_q.line_done;
  assign m_axis_tdata_o  = {{(swt_pkg::OutDataW - 11){1'b0}},
                            out_q.syn_err, out_q.run_bg, out_q.word_end, out_q.word_char};

endmodule

/* dv/swt_checker.sv */
`timescale 1ns / 100ps
// Checker for the shell word tokenizer: predicts each output beat from the accepted input beats
// and compares it with what the block sends. Depends on swt_pkg.
module swt_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_tvalid_i,
  input  logic                         s_tready_i,
  input  logic [7:0]                   s_tdata_i,
  input  logic                         s_tlast_i,
  input  logic                         m_tvalid_i,
  input  logic                         m_tready_i,
  input  logic [swt_pkg::OutDataW-1:0] m_tdata_i,
  input  logic                         m_tuser_i,
  input  logic                         m_tlast_i,
  output int                           pending_o,
  output int                           errors_o
);

  typedef struct packed {
    logic       char_valid;
    logic [7:0] ch;
    logic       word_end;
    logic       line_done;
    logic       run_bg;
    logic       syn_err;
  } token_t;

  token_t     token_q[$];
  logic [1:0] quote_q;
  logic       esc_q;
  logic       open_q;
  logic       amp_q;
  int         errs;

  task automatic clear_line_state();
    quote_q = swt_pkg::QuoteNone;
    esc_q   = 1'b0;
    open_q  = 1'b0;
    amp_q   = 1'b0;
  endtask

  task automatic tokenize_byte(input logic [7:0] b, input logic last);
    logic       have_char;
    logic       ended;
    logic [7:0] closer;
    token_t     t;
    have_char = 1'b0;
    ended     = 1'b0;
    // any mode other than double closes on a single quote
    closer    = (quote_q == swt_pkg::QuoteDouble) ? swt_pkg::ChrDquote : swt_pkg::ChrSquote;
    if (esc_q) begin
      have_char = 1'b1;
      esc_q     = 1'b0;
    end else if (b == swt_pkg::ChrBackslash) begin
      open_q = 1'b1;
      esc_q  = 1'b1;
    end else if (quote_q != swt_pkg::QuoteNone) begin
      if (b == closer) quote_q = swt_pkg::QuoteNone;
      else have_char = 1'b1;
    end else if (b == swt_pkg::ChrSpace || b == swt_pkg::ChrAmp) begin
      if (b == swt_pkg::ChrAmp) amp_q = 1'b1;
      if (open_q) begin
        ended  = 1'b1;
        open_q = 1'b0;
      end
    end else begin
      open_q = 1'b1;
      if (b == swt_pkg::ChrSquote) quote_q = swt_pkg::QuoteSingle;
      else if (b == swt_pkg::ChrDquote) quote_q = swt_pkg::QuoteDouble;
      else have_char = 1'b1;
    end

    t = '0;
    if (!last) begin
      if (have_char || ended) begin
        t.char_valid = have_char;
        t.ch         = have_char ? b : 8'h00;
        t.word_end   = ended;
        token_q.push_back(t);
      end
    end else begin
      t.line_done = 1'b1;
      if (esc_q || quote_q != swt_pkg::QuoteNone) begin
        t.syn_err = 1'b1;  // whole line rejected
      end else begin
        t.char_valid = have_char;
        t.ch         = have_char ? b : 8'h00;
        t.word_end   = ended || open_q;
        t.run_bg     = amp_q;
      end
      token_q.push_back(t);
      clear_line_state();
    end
  endtask

  always @(posedge clk_i) begin
    token_t                       t;
    logic [swt_pkg::OutDataW-1:0] exp_data;
    if (!rst_ni) begin
      clear_line_state();
      token_q.delete();
    end else begin
      // output first: a beat leaving now can't stem from the byte taken at this edge
      if (m_tvalid_i && m_tready_i) begin
        if (token_q.size() == 0) begin
          if (errs < 10)
            $display("%0t chk: unexpected beat tuser=%0b tdata=%04h tlast=%0b",
                     $realtime, m_tuser_i, m_tdata_i, m_tlast_i);
          errs++;
        end else begin
          t        = token_q.pop_front();
          exp_data = '0;
          exp_data[7:0] = t.ch;
          exp_data[8]   = t.word_end;
          exp_data[9]   = t.run_bg;
          exp_data[10]  = t.syn_err;
          if (m_tuser_i !== t.char_valid || m_tdata_i !== exp_data ||
              m_tlast_i !== t.line_done) begin
            if (errs < 10)
              $display("%0t chk: mismatch exp tuser=%0b tdata=%04h tlast=%0b, got %0b %04h %0b",
                       $realtime, t.char_valid, exp_data, t.line_done,
                       m_tuser_i, m_tdata_i, m_tlast_i);
            errs++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) tokenize_byte(s_tdata_i, s_tlast_i);
    end
    pending_o <= token_q.size();
    errors_o  <= errs;
  end

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
// Top of the shell word tokenizer testbench: clock, reset, byte stimulus and output back-pressure.
// Depends on swt_pkg, shell_word_tokenizer and swt_checker.
module tb;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         s_axis_tvalid;
  logic                         s_axis_tready;
  logic [7:0]                   s_axis_tdata;
  logic                         s_axis_tlast;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready;
  logic [swt_pkg::OutDataW-1:0] m_axis_tdata;
  logic                         m_axis_tuser;
  logic                         m_axis_tlast;
  int                           pending;
  int                           errors;

  int bytes_sent = 0;
  bit idle_on    = 1'b1;
  bit long_hold  = 1'b0;
  bit hold_asked = 1'b0;

  shell_word_tokenizer DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  swt_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_i (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tlast_i  (s_axis_tlast),
    .m_tvalid_i (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_i  (m_axis_tdata),
    .m_tuser_i  (m_axis_tuser),
    .m_tlast_i  (m_axis_tlast),
    .pending_o  (pending),
    .errors_o   (errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("tb: done, errors");
    $finish;
  end

  // receiver: random ready bursts, one long hold-off on request
  initial begin
    m_axis_tready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
        long_hold = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
  endtask

  task automatic send_line(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  // biased toward the characters that steer the tokenizer
  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 9))
      0:       return swt_pkg::ChrSpace;
      1:       return swt_pkg::ChrAmp;
      2:       return swt_pkg::ChrBackslash;
      3:       return swt_pkg::ChrSquote;
      4:       return swt_pkg::ChrDquote;
      5:       return 8'($urandom);
      default: return 8'h61 + 8'($urandom_range(0, 25));
    endcase
  endfunction

  task automatic send_random_line();
    int len;
    bit noise;
    len   = $urandom_range(1, 12);
    noise = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < len; i++)
      send_byte(noise ? 8'($urandom) : pick_char(), i == len - 1);
  endtask

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    send_line("a b&");      // word end on space, background flag
    send_line("''");        // empty quotes still make a word
    send_line("' &'");      // quoted blank and ampersand are literal
    send_line("\"\\\"\"");  // escaped double quote inside double quotes
    send_line("\\");        // dangling escape on the last byte
    send_line("\\x");       // escaped character on the last byte
    send_line("'a");        // unclosed quote
    send_line(" ");         // lone blank, nothing open
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);

    while (bytes_sent < 950) begin
      if (!hold_asked && bytes_sent >= 300) begin
        hold_asked = 1'b1;
        long_hold  = 1'b1;
      end
      if (bytes_sent >= 800) idle_on = 1'b0;
      send_random_line();
    end
    s_axis_tvalid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0 && pending == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

endmodule
